/* hw/rtl/waveform_column_plotter_macros.svh */
// assertion macros for the waveform column plotter checker
`ifndef WAVEFORM_COLUMN_PLOTTER_MACROS_SVH
`define WAVEFORM_COLUMN_PLOTTER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wcp_pkg.sv */
package wcp_pkg;

  // field widths
  localparam int SMP_W      = 12;
  localparam int SCORE_W    = 10;
  localparam int ROW_W      = 9;
  localparam int FS_W       = 12;
  localparam int THR_W      = 10;
  localparam int RUN_W      = 4;
  localparam int HOLD_W     = 5;
  localparam int PHASE_W    = 5;

  // divider widths: numerator is row scale times sample
  localparam int DIV_W      = SMP_W + ROW_W;
  localparam int DCNT_W     = $clog2(ROW_W);

  // stream and config port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // register reset values
  localparam logic [FS_W-1:0]   FS_RESET   = 12'd3846;
  localparam logic [THR_W-1:0]  THR_RESET  = 10'd614;
  localparam logic [RUN_W-1:0]  RUN_RESET  = 4'd15;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 5'd16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_RUN_LENGTH = 2'd2,
    CFG_HOLD       = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } wcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } wcp_status_t;

endpackage

/* hw/rtl/wcp_ctrl.sv */
module wcp_ctrl
  import wcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  wcp_status_t status,
  output wcp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/wcp_datapath.sv */
module wcp_datapath
  import wcp_pkg::*;
#(
  parameter int DELAY_LEN   = 192,
  parameter int SCREEN_ROWS = 272
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wcp_cmd_t              cmd,
  output wcp_status_t           status,
  input  logic [SMP_W-1:0]      in_sample,
  input  logic [SCORE_W-1:0]    in_score,
  input  logic                  in_freeze,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_column_valid,
  output logic [ROW_W-1:0]      out_span_top,
  output logic [ROW_W-1:0]      out_span_bottom,
  output logic                  out_artifact_mark,
  output logic                  out_run_model
);

  localparam int PTR_W = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DELAY_LEN - 1);
  localparam logic [ROW_W-1:0] TOP_ROW  = ROW_W'(SCREEN_ROWS - 1);

  // configuration registers
  logic [FS_W-1:0]   full_scale;
  logic [THR_W-1:0]  artifact_threshold;
  logic [RUN_W-1:0]  run_length;
  logic [HOLD_W-1:0] hold_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale         <= FS_RESET;
      artifact_threshold <= THR_RESET;
      run_length         <= RUN_RESET;
      hold_length        <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_FULL_SCALE: full_scale         <= cfg_wdata[FS_W-1:0];
        CFG_THRESHOLD:  artifact_threshold <= cfg_wdata[THR_W-1:0];
        CFG_RUN_LENGTH: run_length         <= cfg_wdata[RUN_W-1:0];
        CFG_HOLD:       hold_length        <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic [SMP_W-1:0]   sample_r;
  logic [SCORE_W-1:0] score_r;
  logic               freeze_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      score_r  <= in_score;
      freeze_r <= in_freeze;
      sat_r    <= (in_sample >= full_scale);
    end
  end

  // row delay memory, read at load, written at finish
  logic [ROW_W-1:0] row_mem [DELAY_LEN];
  logic [ROW_W-1:0] rd_data;
  logic [PTR_W-1:0] ptr;
  logic             filled;
  logic [ROW_W-1:0] new_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= row_mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      row_mem[ptr] <= new_row;
    end
  end

  // pointer walks the memory in order, so one flag marks a full first pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      filled <= 1'b0;
    end else if (cmd.finish) begin
      if (ptr == PTR_LAST) begin
        ptr    <= '0;
        filled <= 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [ROW_W-1:0]  quot;
  logic [DCNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem     <= {{SMP_W{1'b0}}, TOP_ROW} * {{ROW_W{1'b0}}, sample_r};
      dsh     <= {{ROW_W{1'b0}}, full_scale} << (ROW_W - 1);
      quot    <= '0;
      div_cnt <= DCNT_W'(ROW_W - 1);
    end else if (cmd.step) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[ROW_W-2:0], 1'b1};
      end else begin
        quot <= {quot[ROW_W-2:0], 1'b0};
      end
      dsh     <= dsh >> 1;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign new_row = sat_r ? '0 : (TOP_ROW - quot);

  // column state
  logic [ROW_W-1:0]   last_row;
  logic [RUN_W-1:0]   run_count;
  logic [HOLD_W-1:0]  hold_count;
  logic [PHASE_W-1:0] sample_phase;

  logic [ROW_W-1:0]  cur_row;
  logic [RUN_W-1:0]  run_count_next;
  logic [HOLD_W-1:0] hold_count_next;
  logic              mark;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  bottom;

  assign cur_row = filled ? rd_data : TOP_ROW;

  // artifact run detector and hold
  always_comb begin
    run_count_next  = run_count;
    hold_count_next = hold_count;
    mark            = 1'b0;
    if (score_r > artifact_threshold) begin
      if (run_count >= run_length) begin
        hold_count_next = hold_length;
      end else begin
        run_count_next = run_count + 1'b1;
      end
    end else begin
      run_count_next = '0;
    end
    if (hold_count_next != '0) begin
      mark            = 1'b1;
      hold_count_next = hold_count_next - 1'b1;
    end
  end

  // span joining previous and current rows
  always_comb begin
    if (last_row == cur_row) begin
      top    = cur_row;
      bottom = cur_row;
    end else if (last_row > cur_row) begin
      top    = cur_row;
      bottom = last_row - 1'b1;
    end else begin
      top    = last_row + 1'b1;
      bottom = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row     <= '0;
      run_count    <= '0;
      hold_count   <= '0;
      sample_phase <= '0;
    end else if (cmd.finish) begin
      sample_phase <= sample_phase + 1'b1;
      if (!freeze_r) begin
        last_row   <= cur_row;
        run_count  <= run_count_next;
        hold_count <= hold_count_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_column_valid  <= !freeze_r;
      out_span_top      <= freeze_r ? '0 : top;
      out_span_bottom   <= freeze_r ? '0 : bottom;
      out_artifact_mark <= !freeze_r && mark;
      out_run_model     <= (sample_phase == '0);
    end
  end

  assign status.div_last = (div_cnt == '0);
  assign status.out_busy = out_valid && !out_ready;

endmodule

/* hw/rtl/waveform_column_plotter.sv */
// sequence: an input word passes through the accept state, the multiply state, the
//   9-step divider and the finish state, which registers the result word and waits
//   while the previous result is held; a new word is accepted only after the finish
// reset: synchronous active-high rst clears control, counters and registers to
//   their defaults; the row memory is not cleared, unread rows count as the bottom row
module waveform_column_plotter
  import wcp_pkg::*;
#(
  parameter int DELAY_LEN   = 192,
  parameter int SCREEN_ROWS = 272
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample[11:0], artifact_score[21:12], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // freeze
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // span_top[8:0], span_bottom[17:9], artifact_mark[18], run_model[19], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // column_valid
  output logic                  m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wcp_cmd_t         cmd;
  wcp_status_t      status;
  logic [ROW_W-1:0] span_top;
  logic [ROW_W-1:0] span_bottom;
  logic             artifact_mark;
  logic             run_model;

  // registers are always writable
  assign cfg_ready = 1'b1;

  wcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wcp_datapath #(
    .DELAY_LEN   (DELAY_LEN),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_sample         (s_tdata[SMP_W-1:0]),
    .in_score          (s_tdata[SMP_W+SCORE_W-1:SMP_W]),
    .in_freeze         (s_tuser),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_idx           (cfg_index),
    .cfg_wdata         (cfg_data),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_column_valid  (m_tuser),
    .out_span_top      (span_top),
    .out_span_bottom   (span_bottom),
    .out_artifact_mark (artifact_mark),
    .out_run_model     (run_model)
  );

  // pack result word
  assign m_tdata = {{(OUT_DATA_W - 2 * ROW_W - 2){1'b0}},
                    run_model, artifact_mark, span_bottom, span_top};

endmodule

/* hw/rtl/wcp_checker.sv */
`include "waveform_column_plotter_macros.svh"

module wcp_checker
  import wcp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready
);

  // frozen word carries no span and no mark
  `WCP_ASSERT_NOW(a_frozen_blank, m_tvalid && !m_tuser, m_tdata[18:0] == '0, "frozen word not blank")

  // span is never inverted
  `WCP_ASSERT_NOW(a_span_order, m_tvalid && m_tuser, m_tdata[8:0] <= m_tdata[17:9], "span inverted")

  // one word in flight: input closes after an accept
  `WCP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input open after accept")

  // stalled result holds
  `WCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")

endmodule

bind waveform_column_plotter wcp_checker u_wcp_checker (.*);

/* bench/tb_waveform_column_plotter.sv */
`timescale 1ns / 1ps

module tb_waveform_column_plotter
  import wcp_pkg::*;
();

  localparam int DELAY_LEN   = 192;
  localparam int SCREEN_ROWS = 272;
  localparam int TOP_ROW     = SCREEN_ROWS - 1;
  localparam int CYCLE_LIMIT = 400000;

  // one expected column
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic             mark;
    logic             run_model;
  } column_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register copies
  logic [FS_W-1:0]   fs_cfg;
  logic [THR_W-1:0]  thr_cfg;
  logic [RUN_W-1:0]  run_cfg;
  logic [HOLD_W-1:0] hold_cfg;

  // plotter state copies
  logic [ROW_W-1:0]   row_line [DELAY_LEN];
  int                 line_ptr;
  logic [ROW_W-1:0]   prev_row;
  logic [RUN_W-1:0]   run_cnt;
  logic [HOLD_W-1:0]  hold_cnt;
  logic [PHASE_W-1:0] phase;

  column_t expected_columns[$];
  int      error_count     = 0;
  int      column_count    = 0;
  int      cycle_count     = 0;
  int      send_gap_pct    = 0;
  int      recv_stall_pct  = 0;
  int      hold_off_cycles = 0;

  waveform_column_plotter #(
    .DELAY_LEN  (DELAY_LEN),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor: state after reset
  function automatic void reset_plotter();
    fs_cfg   = FS_RESET;
    thr_cfg  = THR_RESET;
    run_cfg  = RUN_RESET;
    hold_cfg = HOLD_RESET;
    for (int i = 0; i < DELAY_LEN; i++) row_line[i] = ROW_W'(TOP_ROW);
    line_ptr = 0;
    prev_row = '0;
    run_cnt  = '0;
    hold_cnt = '0;
    phase    = '0;
  endfunction

  // clamp and scale one sample to a screen row
  function automatic logic [ROW_W-1:0] row_of(logic [SMP_W-1:0] smp);
    int unsigned height;
    if (smp >= fs_cfg) begin
      height = TOP_ROW;
    end else begin
      height = (TOP_ROW * int'(smp)) / int'(fs_cfg);
    end
    return ROW_W'(TOP_ROW - height);
  endfunction

  // advance the predictor by one sample and queue the column it yields
  function automatic void plot_column(logic [SMP_W-1:0] smp, logic [SCORE_W-1:0] scr,
                                      logic frz);
    column_t          col;
    logic [ROW_W-1:0] cur;
    cur = row_line[line_ptr];
    row_line[line_ptr] = row_of(smp);
    line_ptr = (line_ptr == DELAY_LEN - 1) ? 0 : line_ptr + 1;
    col = '0;
    if (!frz) begin
      col.valid = 1'b1;
      if (scr > thr_cfg) begin
        if (run_cnt >= run_cfg) hold_cnt = hold_cfg;
        else run_cnt = run_cnt + 1'b1;
      end else begin
        run_cnt = '0;
      end
      if (hold_cnt != 0) begin
        col.mark = 1'b1;
        hold_cnt = hold_cnt - 1'b1;
      end
      if (prev_row == cur) begin
        col.top    = cur;
        col.bottom = cur;
      end else if (prev_row > cur) begin
        col.top    = cur;
        col.bottom = prev_row - 1'b1;
      end else begin
        col.top    = prev_row + 1'b1;
        col.bottom = cur;
      end
      prev_row = cur;
    end
    col.run_model = (phase == 0);
    phase = phase + 1'b1;
    expected_columns.push_back(col);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("column %0d: %s got %0d expected %0d", column_count, field, got, want);
    error_count++;
  endtask

  // result checker
  initial begin
    column_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_columns.size() == 0) begin
          report_mismatch("unexpected word, queue", 1, 0);
        end else begin
          want = expected_columns.pop_front();
          if (m_tuser !== want.valid)
            report_mismatch("column_valid", int'(m_tuser), int'(want.valid));
          if (m_tdata[8:0] !== want.top)
            report_mismatch("span_top", int'(m_tdata[8:0]), int'(want.top));
          if (m_tdata[17:9] !== want.bottom)
            report_mismatch("span_bottom", int'(m_tdata[17:9]), int'(want.bottom));
          if (m_tdata[18] !== want.mark)
            report_mismatch("artifact_mark", int'(m_tdata[18]), int'(want.mark));
          if (m_tdata[19] !== want.run_model)
            report_mismatch("run_model", int'(m_tdata[19]), int'(want.run_model));
        end
        column_count++;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("waveform_column_plotter: mismatch");
    $finish;
  end

  // offer one sample word, with random gaps before it
  task automatic send_word(logic [SMP_W-1:0] smp, logic [SCORE_W-1:0] scr, logic frz);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {{(IN_DATA_W - SMP_W - SCORE_W){1'b0}}, scr, smp};
    s_tuser  <= frz;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    plot_column(smp, scr, frz);
  endtask

  // stop offering and wait for every expected column
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FULL_SCALE: fs_cfg   = val[FS_W-1:0];
      CFG_THRESHOLD:  thr_cfg  = val[THR_W-1:0];
      CFG_RUN_LENGTH: run_cfg  = val[RUN_W-1:0];
      CFG_HOLD:       hold_cfg = val[HOLD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // write all registers once the block has gone idle
  task automatic set_config(int fs, int thr, int run, int hold);
    wait_drained();
    repeat (16) @(posedge clk);
    write_reg(CFG_FULL_SCALE, CFG_DATA_W'(fs));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_RUN_LENGTH, CFG_DATA_W'(run));
    write_reg(CFG_HOLD, CFG_DATA_W'(hold));
  endtask

  task automatic random_config();
    set_config($urandom_range(4095), $urandom_range(1023), $urandom_range(15),
               $urandom_range(31));
  endtask

  // random samples with bursts of over-threshold scores to reach the hold logic
  task automatic send_random(int count);
    logic [SMP_W-1:0]   smp;
    logic [SCORE_W-1:0] scr;
    logic               frz;
    int                 burst_left;
    int                 pick;
    burst_left = 0;
    smp = SMP_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0 && $urandom_range(99) < 15)
        burst_left = $urandom_range(int'(run_cfg) + 3, 1);
      pick = $urandom_range(99);
      if (pick < 20) smp = smp;
      else if (pick < 30) smp = SMP_W'($urandom_range(4095, fs_cfg));
      else if (pick < 45) smp = SMP_W'($urandom);
      else smp = SMP_W'($urandom_range(fs_cfg));
      if (burst_left > 0) begin
        scr = (thr_cfg == 10'd1023) ? 10'd1023 :
              SCORE_W'($urandom_range(1023, int'(thr_cfg) + 1));
        burst_left--;
      end else if ($urandom_range(1)) begin
        scr = SCORE_W'($urandom_range(thr_cfg));
      end else begin
        scr = SCORE_W'($urandom);
      end
      frz = ($urandom_range(99) < 8);
      send_word(smp, scr, frz);
    end
  endtask

  // field extremes and freeze under reset settings
  task automatic test_directed_defaults();
    send_word(12'd0, 10'd0, 1'b0);
    send_word(12'd4095, 10'd1023, 1'b0);
    send_word(12'd3846, 10'd614, 1'b0);
    send_word(12'd3845, 10'd615, 1'b0);
    send_word(12'd1, 10'd1023, 1'b1);
    send_word(12'd4095, 10'd0, 1'b1);
    send_word(12'd2048, 10'd512, 1'b0);
    send_word(12'd0, 10'd1023, 1'b1);
  endtask

  // zero full scale, zero run and hold lengths, threshold extremes
  task automatic test_degenerate_settings();
    set_config(0, 0, 0, 0);
    send_word(12'd0, 10'd1, 1'b0);
    send_word(12'd4095, 10'd1023, 1'b0);
    send_word(12'd100, 10'd0, 1'b0);
    send_word(12'd7, 10'd1, 1'b0);
    set_config(0, 0, 0, 31);
    send_word(12'd0, 10'd1, 1'b0);
    send_word(12'd0, 10'd1, 1'b1);
    send_word(12'd0, 10'd0, 1'b0);
    send_word(12'd1, 10'd0, 1'b0);
    set_config(4095, 1023, 15, 31);
    send_word(12'd4094, 10'd1023, 1'b0);
    send_word(12'd4095, 10'd1023, 1'b0);
    set_config(1, 0, 1, 1);
    send_word(12'd0, 10'd1, 1'b0);
    send_word(12'd1, 10'd1, 1'b0);
    send_word(12'd0, 10'd1, 1'b0);
    send_word(12'd0, 10'd0, 1'b0);
  endtask

  task automatic test_steady_stream();
    set_config(int'(FS_RESET), int'(THR_RESET), int'(RUN_RESET), int'(HOLD_RESET));
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_sparse_sender();
    set_config(4095, 0, 1, 31);
    send_gap_pct   = 74;
    recv_stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_slow_receiver();
    set_config(1, 1023, 15, 1);
    send_gap_pct   = 0;
    recv_stall_pct = 74;
    send_random(150);
    set_config(2000, 300, 4, 8);
    send_random(150);
  endtask

  task automatic test_mixed_idling();
    random_config();
    send_gap_pct   = 22;
    recv_stall_pct = 22;
    send_random(300);
  endtask

  // long receiver hold-off fills the block, then a full drain between bursts
  task automatic test_backpressure();
    random_config();
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 400;
    send_random(150);
    wait_drained();
    send_gap_pct   = 22;
    recv_stall_pct = 22;
    send_random(150);
  endtask

  initial begin
    reset_plotter();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_degenerate_settings();
    test_steady_stream();
    test_sparse_sender();
    test_slow_receiver();
    test_mixed_idling();
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("waveform_column_plotter: match");
    end else begin
      $display("waveform_column_plotter: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/wcp_pkg.sv
hw/rtl/wcp_ctrl.sv
hw/rtl/wcp_datapath.sv
hw/rtl/waveform_column_plotter.sv
hw/rtl/wcp_checker.sv
bench/tb_waveform_column_plotter.sv
